// File: rtl/core/gbaw_pkg.sv
// Shared types, codes, constants and the exp table function of the Gaussian-blended warp.
package gbaw_pkg;

  // Command codes carried on in_tuser
  localparam logic [1:0] CMD_CENTER = 2'd0;
  localparam logic [1:0] CMD_COEF   = 2'd1;
  localparam logic [1:0] CMD_POINT  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SIGMA_X = 2'd0;
  localparam logic [1:0] CFG_SIGMA_Y = 2'd1;
  localparam logic [1:0] CFG_SIGMA_Z = 2'd2;
  localparam logic [1:0] CFG_CENTERS = 2'd3;

  localparam int NCOEF   = 12;
  localparam int QB      = 33;          // quotient bits of the shared divider
  localparam int DIV_DW  = 31;          // divisor width
  localparam logic [29:0] D2_LIMIT = 30'(16 << 16);
  localparam logic [22:0] Q_CAP    = 23'(1 << 22);
  localparam longint unsigned E_INV_Q32 = 64'd1580030169;

  // Divider status
  typedef struct packed {
    logic done;
    logic ovf;
  } div_rsp_t;

  // exp(-a) for a in Q16.16 below 8.0, unsigned Q0.16
  function automatic logic [15:0] exp_neg(input longint unsigned a);
    longint unsigned n;
    longint unsigned f;
    longint unsigned tm;
    longint unsigned res;
    longint sum;
    n   = a >> 16;
    f   = a & 64'hFFFF;
    tm  = 64'h1_0000_0000;
    sum = longint'(tm);
    tm = ((tm * f) >> 16) / 1;  sum = sum - longint'(tm);
    tm = ((tm * f) >> 16) / 2;  sum = sum + longint'(tm);
    tm = ((tm * f) >> 16) / 3;  sum = sum - longint'(tm);
    tm = ((tm * f) >> 16) / 4;  sum = sum + longint'(tm);
    tm = ((tm * f) >> 16) / 5;  sum = sum - longint'(tm);
    tm = ((tm * f) >> 16) / 6;  sum = sum + longint'(tm);
    tm = ((tm * f) >> 16) / 7;  sum = sum - longint'(tm);
    tm = ((tm * f) >> 16) / 8;  sum = sum + longint'(tm);
    tm = ((tm * f) >> 16) / 9;  sum = sum - longint'(tm);
    tm = ((tm * f) >> 16) / 10; sum = sum + longint'(tm);
    tm = ((tm * f) >> 16) / 11; sum = sum - longint'(tm);
    tm = ((tm * f) >> 16) / 12; sum = sum + longint'(tm);
    tm = ((tm * f) >> 16) / 13; sum = sum - longint'(tm);
    tm = ((tm * f) >> 16) / 14; sum = sum + longint'(tm);
    res = (sum > 0) ? longint'(sum) : 64'd0;
    for (int k = 0; k < 8; k++) begin
      if (longint'(k) < longint'(n)) res = (res * E_INV_Q32) >> 32;
    end
    res = (res + 64'd32768) >> 16;
    return (res > 64'd65535) ? 16'hFFFF : res[15:0];
  endfunction

endpackage

// File: rtl/core/gaussian_blended_affine_warp.sv
// Top level of the Gaussian-blended affine warp: tables, sequencer and shared datapath.
//
// Channels: in_* carries one beat per command; in_tuser is the command (center write,
// coefficient write, transform). Table writes give no result.
// A transform beat yields one out_* beat: the warped point on out_tdata and the
// weight-clamped flag on out_tuser. Registers are written through cfg_*; they are to be
// written only while idle, and the block itself does not enforce this.
// A transform works, for each center in use, three axis steps, one weight lookup and
// the twelve weighted coefficients; then each of the twelve mean coefficients, each
// output row and the output load. The shared 33-step divider gives three axis quotients
// per center and the twelve mean coefficients; the steps share the single multiplier
// and the center and matrix memories, each with a single read port.
// in_tready is high only while the sequencer is idle; one item is worked at a time.
// A finished result waits in the output register, so the next beat is taken while
// the receiver stalls; a second finished result waits until that register drains.
// Reset sets the sigmas to 1.0 and the center count to zero and drops any pending
// result; table contents are undefined until written.
module gaussian_blended_affine_warp import gbaw_pkg::*; #(
  parameter int MAX_CENTERS     = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // entry_index[3:0], element_index[7:4], table_value[39:8],
  // point_x[71:40], point_y[103:72], point_z[135:104]
  input  logic [135:0]  in_tdata,
  // cmd[1:0]
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]   out_tdata,
  // weight_clamped[0]
  output logic          out_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [30:0]   cfg_wdata
);

  localparam int CL  = $clog2(MAX_CENTERS + 1);
  localparam int BW  = 48 + CL;
  localparam int NW  = (BW > 49) ? BW : 49;
  localparam int WW  = 16 + CL;
  localparam int AW  = 52;
  localparam int KW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int CAW = $clog2(MAX_CENTERS * 3);
  localparam int MAW = $clog2(MAX_CENTERS * NCOEF);
  localparam int EW  = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_C_RD   = 16'b0000_0000_0000_0010,
    S_C_DIFF = 16'b0000_0000_0000_0100,
    S_C_DIV  = 16'b0000_0000_0000_1000,
    S_C_SQ   = 16'b0000_0000_0001_0000,
    S_C_ADD  = 16'b0000_0000_0010_0000,
    S_WGT    = 16'b0000_0000_0100_0000,
    S_M_RD   = 16'b0000_0000_1000_0000,
    S_M_MUL  = 16'b0000_0001_0000_0000,
    S_M_ACC  = 16'b0000_0010_0000_0000,
    S_N_ST   = 16'b0000_0100_0000_0000,
    S_N_DIV  = 16'b0000_1000_0000_0000,
    S_A_INIT = 16'b0001_0000_0000_0000,
    S_A_MUL  = 16'b0010_0000_0000_0000,
    S_A_ACC  = 16'b0100_0000_0000_0000,
    S_FIN    = 16'b1000_0000_0000_0000
  } st_t;

  st_t st_r;

  // Input fields
  logic [3:0]         f_entry, f_elem;
  logic signed [31:0] f_value;
  assign f_entry = in_tdata[3:0];
  assign f_elem  = in_tdata[7:4];
  assign f_value = in_tdata[39:8];

  logic accept;
  assign in_tready = (st_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Configuration registers
  logic [30:0] sig_r [3];
  logic [4:0]  ncen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r[0] <= 31'd65536;
      sig_r[1] <= 31'd65536;
      sig_r[2] <= 31'd65536;
      ncen_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIGMA_X: sig_r[0] <= cfg_wdata;
        CFG_SIGMA_Y: sig_r[1] <= cfg_wdata;
        CFG_SIGMA_Z: sig_r[2] <= cfg_wdata;
        CFG_CENTERS: ncen_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Exp table as constant logic
  logic [15:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam longint unsigned ARG = (longint'(g) << 19) / EXP_TABLE_DEPTH;
    assign exp_rom[g] = exp_neg(ARG);
  end

  // Working registers
  logic signed [31:0] p_r [3];
  logic [KW-1:0]      k_r, last_r;
  logic [1:0]         sub_r, row_r;
  logic [3:0]         coef_r;
  logic [29:0]        d2_r;
  logic [22:0]        q_r;
  logic [15:0]        w_r;
  logic [WW-1:0]      wsum_r;
  logic signed [BW-1:0] blend_r [NCOEF];
  logic signed [33:0] mean_r [NCOEF];
  logic signed [AW-1:0] acc_r;
  logic signed [31:0] res_r [3];
  logic signed [66:0] prod_r;

  // Table memories with registered reads
  logic signed [31:0] cmem [MAX_CENTERS * 3];
  logic signed [31:0] mmem [MAX_CENTERS * NCOEF];
  logic signed [31:0] cdat_r, mdat_r;
  logic [CAW-1:0]     c_waddr, c_raddr;
  logic [MAW-1:0]     m_waddr, m_raddr;

  assign c_waddr = CAW'(int'(f_entry) * 3 + int'(f_elem));
  assign m_waddr = MAW'(int'(f_entry) * NCOEF + int'(f_elem));
  assign c_raddr = CAW'(int'(k_r) * 3 + int'(sub_r));
  assign m_raddr = MAW'(int'(k_r) * NCOEF + int'(coef_r));

  always_ff @(posedge clk) begin
    if (accept && in_tuser == CMD_CENTER && int'(f_entry) < MAX_CENTERS && f_elem < 4'd3)
      cmem[c_waddr] <= f_value;
    if (accept && in_tuser == CMD_COEF && int'(f_entry) < MAX_CENTERS && f_elem < 4'd12)
      mmem[m_waddr] <= f_value;
    cdat_r <= cmem[c_raddr];
    mdat_r <= mmem[m_raddr];
  end

  // Per-axis selection of point coordinate and sigma
  logic signed [31:0] p_sel;
  logic [30:0]        sig_sel;
  always_comb begin
    case (sub_r)
      2'd0:    begin p_sel = p_r[0]; sig_sel = sig_r[0]; end
      2'd1:    begin p_sel = p_r[1]; sig_sel = sig_r[1]; end
      default: begin p_sel = p_r[2]; sig_sel = sig_r[2]; end
    endcase
  end

  // Divider operand selection
  logic signed [33:0] diff;
  logic [32:0]        dmag;
  logic [DIV_DW-1:0]  wden;
  logic signed [BW-1:0] bsel;
  logic [BW-1:0]      bmag;
  logic [NW-1:0]      div_num;
  logic [DIV_DW-1:0]  div_den;
  logic               div_start;
  logic [QB-1:0]      div_quo;
  div_rsp_t           div_rsp;

  assign diff = 34'(p_sel) - 34'(cdat_r);
  assign dmag = diff[33] ? 33'(-diff) : diff[32:0];
  assign wden = (wsum_r == '0) ? DIV_DW'(1) : DIV_DW'(wsum_r);
  assign bsel = blend_r[coef_r];
  assign bmag = bsel[BW-1] ? BW'(-bsel) : BW'(bsel);

  always_comb begin
    if (st_r == S_N_ST) begin
      div_num = NW'(bmag) + NW'(wden >> 1);
      div_den = wden;
    end else begin
      div_num = NW'({dmag, 16'b0});
      div_den = (sig_sel == '0) ? DIV_DW'(1) : sig_sel;
    end
  end
  assign div_start = (st_r == S_C_DIFF) || (st_r == S_N_ST);

  gbaw_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rsp   (div_rsp)
  );

  // Shared multiplier operand selection
  logic [3:0]         m_idx;
  logic signed [33:0] mean_sel;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;

  assign m_idx    = (st_r == S_A_INIT) ? 4'(int'(row_r) * 4 + 3)
                                       : 4'(int'(row_r) * 4 + int'(sub_r));
  assign mean_sel = mean_r[m_idx];

  always_comb begin
    case (st_r)
      S_C_SQ:  begin mul_a = 34'(q_r); mul_b = 33'(q_r); end
      S_M_MUL: begin mul_a = 34'(w_r); mul_b = 33'(mdat_r); end
      default: begin mul_a = mean_sel; mul_b = 33'(p_sel); end
    endcase
  end

  // Weight lookup
  logic [32:0] eprod;
  logic [15:0] w_nxt;
  assign eprod = 33'(d2_r[19:0]) * 33'(EXP_TABLE_DEPTH);
  assign w_nxt = (d2_r >= D2_LIMIT) ? 16'd0 : exp_rom[eprod[20 +: EW]];

  // Rounded product term, half away from zero, and saturation
  logic [66:0]          pmag;
  logic [66:0]          pround;
  logic signed [AW-1:0] term, acc_sum;
  logic signed [31:0]   sat_val;
  assign pmag    = prod_r[66] ? 67'(-prod_r) : 67'(prod_r);
  assign pround  = (pmag + 67'd32768) >> 16;
  assign term    = prod_r[66] ? AW'(-$signed(pround[AW-1:0])) : $signed(pround[AW-1:0]);
  assign acc_sum = acc_r + term;
  always_comb begin
    if (acc_sum > AW'(64'sd2147483647))       sat_val = 32'sh7FFF_FFFF;
    else if (acc_sum < -AW'(64'sd2147483648)) sat_val = 32'sh8000_0000;
    else                                      sat_val = acc_sum[31:0];
  end

  logic [32:0] used;
  assign used = (33'(ncen_r) > 33'(MAX_CENTERS)) ? 33'(MAX_CENTERS) : 33'(ncen_r);

  // Output register
  logic [95:0] out_data_r;
  logic        out_user_r, out_valid_r;
  logic        out_free;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result beat when it is loaded, drop it once taken
      if (st_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_tready)           out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (accept && in_tuser == CMD_POINT) begin
            st_r <= (used == '0) ? S_N_ST : S_C_RD;
          end
        end
        S_C_RD:   st_r <= S_C_DIFF;
        S_C_DIFF: st_r <= S_C_DIV;
        S_C_DIV:  if (div_rsp.done) st_r <= S_C_SQ;
        S_C_SQ:   st_r <= S_C_ADD;
        S_C_ADD:  st_r <= (sub_r == 2'd2) ? S_WGT : S_C_RD;
        S_WGT:    st_r <= S_M_RD;
        S_M_RD:   st_r <= S_M_MUL;
        S_M_MUL:  st_r <= S_M_ACC;
        S_M_ACC: begin
          if (coef_r != 4'(NCOEF - 1)) st_r <= S_M_RD;
          else if (k_r == last_r)      st_r <= S_N_ST;
          else                         st_r <= S_C_RD;
        end
        S_N_ST:   st_r <= S_N_DIV;
        S_N_DIV: begin
          if (div_rsp.done) st_r <= (coef_r == 4'(NCOEF - 1)) ? S_A_INIT : S_N_ST;
        end
        S_A_INIT: st_r <= S_A_MUL;
        S_A_MUL:  st_r <= S_A_ACC;
        S_A_ACC: begin
          if (sub_r != 2'd2)      st_r <= S_A_MUL;
          else if (row_r == 2'd2) st_r <= S_FIN;
          else                    st_r <= S_A_INIT;
        end
        S_FIN: begin
          if (out_free) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (st_r)
      S_IDLE: begin
        if (accept && in_tuser == CMD_POINT) begin
          p_r[0] <= in_tdata[71:40];
          p_r[1] <= in_tdata[103:72];
          p_r[2] <= in_tdata[135:104];
          k_r    <= '0;
          last_r <= KW'(used - 33'd1);
          sub_r  <= '0;
          coef_r <= '0;
          d2_r   <= '0;
          wsum_r <= '0;
          for (int i = 0; i < NCOEF; i++) blend_r[i] <= '0;
        end
      end
      S_C_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.ovf || div_quo > QB'(Q_CAP)) q_r <= Q_CAP;
          else                                       q_r <= div_quo[22:0];
        end
      end
      S_C_ADD: begin
        d2_r  <= d2_r + 30'(prod_r[45:16]);
        sub_r <= sub_r + 2'd1;
      end
      S_WGT: begin
        w_r    <= w_nxt;
        wsum_r <= wsum_r + WW'(w_nxt);
        coef_r <= '0;
      end
      S_M_ACC: begin
        blend_r[coef_r] <= blend_r[coef_r] + prod_r[BW-1:0];
        if (coef_r != 4'(NCOEF - 1)) begin
          coef_r <= coef_r + 4'd1;
        end else begin
          coef_r <= '0;
          sub_r  <= '0;
          d2_r   <= '0;
          k_r    <= k_r + KW'(1);
        end
      end
      S_N_DIV: begin
        if (div_rsp.done) begin
          mean_r[coef_r] <= bsel[BW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          coef_r         <= coef_r + 4'd1;
          row_r          <= '0;
        end
      end
      S_A_INIT: begin
        acc_r <= AW'(mean_sel);
        sub_r <= '0;
      end
      S_A_ACC: begin
        acc_r <= acc_sum;
        sub_r <= sub_r + 2'd1;
        if (sub_r == 2'd2) begin
          res_r[row_r] <= sat_val;
          row_r        <= row_r + 2'd1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_data_r <= {res_r[2], res_r[1], res_r[0]};
          out_user_r <= (wsum_r == '0);
        end
      end
      default: ;
    endcase
  end

  // Divider completes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (st_r == S_C_DIV || st_r == S_N_DIV))
    else $error("divider done outside a wait state");

  // Distance past the cutoff gives zero weight
  a_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WGT && d2_r >= D2_LIMIT) |=> (w_r == 16'd0))
    else $error("nonzero weight past cutoff");

  // A finished result is presented once the output register is free
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && out_free) |=> (out_tvalid && st_r == S_IDLE))
    else $error("finished result not presented");

  // A clamped weight total means an all-zero blended point
  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 96'd0))
    else $error("clamped result not zero");

endmodule

// File: rtl/core/gbaw_div.sv
// Shared restoring divider: one quotient bit per cycle, with overflow flag.
module gbaw_div import gbaw_pkg::*; #(
  parameter int NW = 53
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NW-1:0]     num,
  input  logic [DIV_DW-1:0] den,
  output logic [QB-1:0]     quo,
  output div_rsp_t          rsp
);

  localparam int HW = NW - QB;
  localparam int CW = (HW > DIV_DW) ? HW : DIV_DW;

  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [QB-1:0]     low_r;
  logic [QB-1:0]     quo_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r, ovf_r;
  logic [DIV_DW:0]   trial;
  logic              qbit;
  logic [HW-1:0]     hi;

  assign hi    = num[NW-1:QB];
  assign trial = {rem_r, low_r[QB-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt = qbit ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
  end

  // Control: count quotient bits and pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 6'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(QB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: load the high part as remainder, shift in the low bits
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      ovf_r <= (CW'(hi) >= CW'(den));
      rem_r <= DIV_DW'(hi);
      low_r <= num[QB-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[QB-2:0], 1'b0};
      quo_r <= {quo_r[QB-2:0], qbit};
    end
  end

  assign quo      = quo_r;
  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;

endmodule
